// ===== hw/rtl/tiled_matrix_multiply_defines.svh =====
// ----------------------------------------------------------------------------
// Tiled matrix multiply assertion macros
// Concurrent assertion shorthands on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef TILED_MATRIX_MULTIPLY_DEFINES_SVH
`define TILED_MATRIX_MULTIPLY_DEFINES_SVH

// same-cycle implication
`define TMM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tmm_pkg.sv =====
// ----------------------------------------------------------------------------
// Tiled matrix multiply package
// Sizes, request codes, payload and control structs shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package tmm_pkg;

    localparam int MAX_DIM  = 16;
    localparam int TILE_DIM = 8;
    localparam int IDX_W    = 4;
    localparam int DIM_W    = 5;
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = MAX_DIM * MAX_DIM;
    localparam int ELEM_W   = 16;
    localparam int PROD_W   = 2 * ELEM_W;
    localparam int ACC_W    = 40;

    localparam logic [DIM_W-1:0] SIZE_RESET = DIM_W'(MAX_DIM);

    typedef enum logic [1:0] {
        REQ_WRITE_A = 2'd0,
        REQ_WRITE_B = 2'd1,
        REQ_COMPUTE = 2'd2,
        REQ_READ_C  = 2'd3
    } req_code_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        req_code_t                 req_type;
        logic [IDX_W-1:0]          row_index;
        logic [IDX_W-1:0]          col_index;
        logic signed [ELEM_W-1:0]  element_value;
    } req_t;

    typedef struct packed {
        logic signed [ACC_W-1:0]   product_value;
        logic                      holds_data;
    } rsp_t;

    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic rd_c;
        logic rsp_load;
        logic rsp_read;
    } host_cmd_t;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic             zero;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] k;
    } mac_cmd_t;

    typedef struct packed {
        logic rsp_free;
        logic pipe_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tmm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Tiled matrix multiply controller
// Accepts requests, holds the size register and sweeps the product tile by
// tile, issuing one multiply-accumulate beat per cycle to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module tmm_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tmm_pkg::DIM_W-1:0]   cfg_wdata,
    input  logic                        req_valid,
    input  tmm_pkg::req_code_t          req_type,
    output logic                        req_stall,
    input  tmm_pkg::dp_status_t         status,
    output tmm_pkg::host_cmd_t          host_cmd,
    output tmm_pkg::mac_cmd_t           mac_cmd
);
    import tmm_pkg::*;

    localparam logic [IDX_W-1:0] TILE_LAST = IDX_W'(TILE_DIM - 1);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(MAX_DIM - 1);
    localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] TILE_STEP = DIM_W'(TILE_DIM);

    state_t           state_reg, state_next;
    logic [DIM_W-1:0] size_reg;
    logic [IDX_W-1:0] base_row_reg, base_row_next;
    logic [IDX_W-1:0] base_col_reg, base_col_next;
    logic [IDX_W-1:0] off_row_reg, off_row_next;
    logic [IDX_W-1:0] off_col_reg, off_col_next;
    logic [IDX_W-1:0] k_reg, k_next;

    logic [DIM_W-1:0] dim;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             in_dim;
    logic             k_last;
    logic             elem_last;
    logic             col_end;
    logic             row_end;
    logic             tcol_end;
    logic             trow_end;
    logic             sweep_last;
    logic             accept;

    assign dim       = (size_reg > DIM_MAX) ? DIM_MAX : size_reg;
    assign row       = base_row_reg + off_row_reg;
    assign col       = base_col_reg + off_col_reg;
    assign in_dim    = ({1'b0, row} < dim) && ({1'b0, col} < dim);
    assign k_last    = ({1'b0, k_reg} == (dim - DIM_W'(1)));
    assign elem_last = !in_dim || k_last;
    assign col_end   = (off_col_reg == TILE_LAST) || (col == IDX_LAST);
    assign row_end   = (off_row_reg == TILE_LAST) || (row == IDX_LAST);
    assign tcol_end  = ({1'b0, base_col_reg} + TILE_STEP) >= DIM_MAX;
    assign trow_end  = ({1'b0, base_row_reg} + TILE_STEP) >= DIM_MAX;
    assign sweep_last = elem_last && col_end && row_end && tcol_end && trow_end;
    assign accept    = (state_reg == ST_IDLE) && req_valid && status.rsp_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            size_reg     <= SIZE_RESET;
            base_row_reg <= '0;
            base_col_reg <= '0;
            off_row_reg  <= '0;
            off_col_reg  <= '0;
            k_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            base_row_reg <= base_row_next;
            base_col_reg <= base_col_next;
            off_row_reg  <= off_row_next;
            off_col_reg  <= off_col_next;
            k_reg        <= k_next;
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_COMPUTE))
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        base_row_next = base_row_reg;
        base_col_next = base_col_reg;
        off_row_next  = off_row_reg;
        off_col_next  = off_col_reg;
        k_next        = k_reg;
        if (state_reg != ST_SWEEP)
        begin
            base_row_next = '0;
            base_col_next = '0;
            off_row_next  = '0;
            off_col_next  = '0;
            k_next        = '0;
        end
        else if (!elem_last)
        begin
            k_next = k_reg + IDX_W'(1);
        end
        else
        begin
            k_next = '0;
            if (!col_end)
            begin
                off_col_next = off_col_reg + IDX_W'(1);
            end
            else
            begin
                off_col_next = '0;
                if (!row_end)
                begin
                    off_row_next = off_row_reg + IDX_W'(1);
                end
                else
                begin
                    off_row_next = '0;
                    if (!tcol_end)
                    begin
                        base_col_next = base_col_reg + IDX_W'(TILE_DIM);
                    end
                    else
                    begin
                        base_col_next = '0;
                        if (!trow_end)
                        begin
                            base_row_next = base_row_reg + IDX_W'(TILE_DIM);
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        req_stall         = !((state_reg == ST_IDLE) && status.rsp_free);
        host_cmd.wr_a     = accept && (req_type == REQ_WRITE_A);
        host_cmd.wr_b     = accept && (req_type == REQ_WRITE_B);
        host_cmd.rd_c     = accept && (req_type == REQ_READ_C);
        host_cmd.rsp_read = accept && (req_type == REQ_READ_C);
        host_cmd.rsp_load = (accept && (req_type != REQ_COMPUTE))
                          || ((state_reg == ST_DRAIN) && !status.pipe_busy);
        mac_cmd.valid     = (state_reg == ST_SWEEP);
        mac_cmd.first     = (k_reg == '0);
        mac_cmd.last      = elem_last;
        mac_cmd.zero      = !in_dim;
        mac_cmd.row       = row;
        mac_cmd.col       = col;
        mac_cmd.k         = k_reg;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tmm_datapath.sv =====
// ----------------------------------------------------------------------------
// Tiled matrix multiply datapath
// Operand and product memories, the multiply-accumulate pipeline and the
// response register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmm_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tmm_pkg::req_t           req,
    input  tmm_pkg::host_cmd_t      host_cmd,
    input  tmm_pkg::mac_cmd_t       mac_cmd,
    input  logic                    rsp_stall,
    output logic                    rsp_valid,
    output tmm_pkg::rsp_t           rsp,
    output tmm_pkg::dp_status_t     status
);
    import tmm_pkg::*;

    logic signed [ELEM_W-1:0] left_mem  [DEPTH];
    logic signed [ELEM_W-1:0] right_mem [DEPTH];
    logic signed [ACC_W-1:0]  product_mem [DEPTH];

    logic [ADDR_W-1:0]        host_addr;

    logic signed [ELEM_W-1:0] a_rd_reg;
    logic signed [ELEM_W-1:0] b_rd_reg;
    logic                     s1_valid_reg;
    logic                     s1_first_reg;
    logic                     s1_last_reg;
    logic                     s1_zero_reg;
    logic [ADDR_W-1:0]        s1_addr_reg;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     s2_valid_reg;
    logic                     s2_first_reg;
    logic                     s2_last_reg;
    logic [ADDR_W-1:0]        s2_addr_reg;

    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  c_rd_reg;

    logic                     rsp_valid_reg, rsp_valid_next;
    logic                     rsp_read_reg;

    assign host_addr = {req.row_index, req.col_index};

    always_ff @(posedge clk)
    begin
        if (host_cmd.wr_a)
        begin
            left_mem[host_addr] <= req.element_value;
        end
        if (host_cmd.wr_b)
        begin
            right_mem[host_addr] <= req.element_value;
        end
        if (mac_cmd.valid)
        begin
            a_rd_reg <= left_mem[{mac_cmd.row, mac_cmd.k}];
            b_rd_reg <= right_mem[{mac_cmd.k, mac_cmd.col}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s2_last_reg)
        begin
            product_mem[s2_addr_reg] <= acc_next;
        end
        if (host_cmd.rd_c)
        begin
            c_rd_reg <= product_mem[host_addr];
        end
    end

    always_comb
    begin
        prod_next = '0;
        if (!s1_zero_reg)
        begin
            prod_next = a_rd_reg * b_rd_reg;
        end
        acc_next  = (s2_first_reg ? '0 : acc_reg) + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= mac_cmd.first;
        s1_last_reg  <= mac_cmd.last;
        s1_zero_reg  <= mac_cmd.zero;
        s1_addr_reg  <= {mac_cmd.row, mac_cmd.col};
        prod_reg     <= prod_next;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_addr_reg  <= s1_addr_reg;
        if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (host_cmd.rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_read_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= mac_cmd.valid;
            s2_valid_reg  <= s1_valid_reg;
            rsp_valid_reg <= rsp_valid_next;
            if (host_cmd.rsp_load)
            begin
                rsp_read_reg <= host_cmd.rsp_read;
            end
        end
    end

    assign rsp_valid          = rsp_valid_reg;
    assign rsp.product_value  = rsp_read_reg ? c_rd_reg : '0;
    assign rsp.holds_data     = rsp_read_reg;
    assign status.rsp_free    = !rsp_valid_reg || !rsp_stall;
    assign status.pipe_busy   = s1_valid_reg || s2_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tiled_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// Tiled matrix multiply
// Square Q8.8 matrix product C = A x B over 8x8 tiles, exact Q24.16 results.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req): one beat per request.
//   Write A and write B store one element; read C returns one element;
//   compute rebuilds all of C. Every request yields exactly one response beat
//   on rsp_valid / rsp_stall / rsp, in request order.
//   cfg_we / cfg_wdata set the matrix size (1..16, larger values act as 16);
//   write it only while no request is outstanding.
//   Writes and reads: response in the cycle after the request beat, one request
//   per cycle while responses are taken.
//   Compute: one multiply-accumulate per cycle through a single multiplier,
//   one beat per element outside the size to clear it.
//   Requests stall during a compute.
//   A stalled response holds its beat and stalls the request channel.
//   Reset empties the response register and sets the size to 16; operand
//   and product memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module tiled_matrix_multiply (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tmm_pkg::DIM_W-1:0]   cfg_wdata,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  tmm_pkg::req_t               req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output tmm_pkg::rsp_t               rsp
);
    import tmm_pkg::*;

    host_cmd_t  host_cmd;
    mac_cmd_t   mac_cmd;
    dp_status_t status;

    tmm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .req_stall (req_stall),
        .status    (status),
        .host_cmd  (host_cmd),
        .mac_cmd   (mac_cmd)
    );

    tmm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .host_cmd  (host_cmd),
        .mac_cmd   (mac_cmd),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .status    (status)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/tmm_checker.sv =====
// ----------------------------------------------------------------------------
// Tiled matrix multiply checker
// Port-level assertions on request and response behavior, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tiled_matrix_multiply_defines.svh"

module tmm_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tmm_pkg::DIM_W-1:0]   cfg_wdata,
    input  logic                        req_valid,
    input  logic                        req_stall,
    input  tmm_pkg::req_t               req,
    input  logic                        rsp_valid,
    input  logic                        rsp_stall,
    input  tmm_pkg::rsp_t               rsp
);
    import tmm_pkg::*;

    `TMM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response beat changed")
    `TMM_ASSERT_SAME(a_rsp_zero, rsp_valid && !rsp.holds_data, rsp.product_value == '0, "non-read response carries data")
    `TMM_ASSERT_NEXT(a_quick_rsp, req_valid && !req_stall && req.req_type != REQ_COMPUTE, rsp_valid, "element request response late")
    `TMM_ASSERT_NEXT(a_read_flag, req_valid && !req_stall && req.req_type == REQ_READ_C, rsp.holds_data, "read response lacks data flag")
    `TMM_ASSERT_NEXT(a_busy, req_valid && !req_stall && req.req_type == REQ_COMPUTE, req_stall, "request taken during compute")

endmodule

bind tiled_matrix_multiply tmm_checker u_checker (.*);

`default_nettype wire
